### rtl/lobm_pkg.sv
// Shared types and constants for the order book matcher.
`default_nettype none
package lobm_pkg;

  localparam int MAX_ORDERS = 32;
  localparam int IDX_W = $clog2(MAX_ORDERS);

  localparam logic [1:0] CMD_LIMIT  = 2'd0;
  localparam logic [1:0] CMD_MARKET = 2'd1;

  localparam logic [2:0] ST_FILLED    = 3'd0;
  localparam logic [2:0] ST_RESTED    = 3'd1;
  localparam logic [2:0] ST_DROPPED   = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] order_id;
    logic        order_side;
    logic [31:0] limit_price;
    logic [31:0] order_quantity;
    logic [63:0] order_time;
  } lobm_in_t;

  typedef struct packed {
    logic        item_kind;
    logic [2:0]  status;
    logic [31:0] taker_id;
    logic [31:0] maker_id;
    logic [31:0] trade_price;
    logic [31:0] trade_quantity;
    logic [63:0] trade_time;
    logic        last;
  } lobm_out_t;

endpackage
`default_nettype wire

### rtl/limit_order_book_matcher_top.sv
// Top level of the price-time priority order book matcher.
//
// Usage: drive in_data and pulse start while busy is low; the command is
// transferred at that edge and busy rises. Each result is shown for one cycle
// with out_valid high; the receiver cannot stall. out_data.last marks the
// final status record of a command.
// Timing: the table of MAX_ORDERS entries is scanned one entry per cycle by a
// single compare unit, and each scan ends in the trade or decision state
// S_TRADE. A cancel runs one scan and its status is registered from S_TRADE.
// A submit of nonzero quantity runs one scan per trade, and one more scan that
// finds no crossing entry unless it fills; a resting submit then searches for
// a free entry in S_FREE, and the status is registered from S_DONE.
// Busy falls as the status is shown, so the next command can be transferred
// in that cycle. The entry scan sets the rate.
// Reset: rst_n low clears all valid bits and the arrival counter; entry data
// is not cleared and is read only behind a valid bit.
`default_nettype none
module limit_order_book_matcher_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire lobm_pkg::lobm_in_t in_data,
  output logic                    out_valid,
  output lobm_pkg::lobm_out_t     out_data
);
  import lobm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_TRADE, S_FREE, S_DONE
  } state_t;

  state_t               state_r;
  lobm_in_t             cmd_r;
  logic [31:0]          rem_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 found_r;
  logic [IDX_W-1:0]     best_r;
  logic [31:0]          bp_r;
  logic [31:0]          ba_r;
  logic [MAX_ORDERS-1:0] valid_r;
  logic [31:0]          arrival_r;
  logic                 out_valid_r;
  lobm_out_t            out_r;

  logic [31:0] mem_id    [MAX_ORDERS];
  logic        mem_side  [MAX_ORDERS];
  logic [31:0] mem_price [MAX_ORDERS];
  logic [31:0] mem_rem   [MAX_ORDERS];
  logic [31:0] mem_seq   [MAX_ORDERS];

  // scan compare unit
  logic        is_cancel, is_market, last_idx;
  logic [31:0] e_price, e_age, m_qty, b_price, b_rem;
  logic        hit, better, crosses;
  assign is_cancel = cmd_r.command[1];
  assign is_market = cmd_r.command[0];
  assign last_idx  = (idx_r == IDX_W'(MAX_ORDERS - 1));
  assign e_price   = mem_price[idx_r];
  assign e_age     = arrival_r - mem_seq[idx_r];
  assign b_price   = mem_price[best_r];
  assign b_rem     = mem_rem[best_r];
  assign m_qty     = (rem_r < b_rem) ? rem_r : b_rem;
  assign crosses   = is_market ||
                     (cmd_r.order_side ? (cmd_r.limit_price <= b_price)
                                       : (cmd_r.limit_price >= b_price));

  always_comb begin
    if (is_cancel) begin
      hit    = valid_r[idx_r] && (mem_id[idx_r] == cmd_r.order_id) && !found_r;
      better = hit;
    end else begin
      hit = valid_r[idx_r] && (mem_side[idx_r] != cmd_r.order_side);
      if (!found_r) better = hit;
      else if (e_price != bp_r)
        better = hit && (cmd_r.order_side ? (e_price > bp_r) : (e_price < bp_r));
      else better = hit && (e_age > ba_r);
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sequence scans, trades and status
  always_ff @(posedge clk) begin
    // show a result after a cancel, a trade or the final status
    out_valid_r <= rst_n && ((state_r == S_DONE) ||
                   ((state_r == S_TRADE) && (is_cancel || (found_r && crosses))));
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      arrival_r <= '0;
      found_r   <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (start) begin
          cmd_r   <= in_data;
          rem_r   <= in_data.order_quantity;
          idx_r   <= '0;
          found_r <= 1'b0;
          if (in_data.command[1] || in_data.order_quantity != '0) state_r <= S_SCAN;
          else state_r <= S_DONE;
        end
        S_SCAN: begin
          if (better) begin
            found_r <= 1'b1;
            best_r  <= idx_r;
            bp_r    <= e_price;
            ba_r    <= e_age;
          end
          idx_r <= idx_r + 1'b1;
          if (last_idx) state_r <= S_TRADE;
        end
        S_TRADE: begin
          idx_r   <= '0;
          found_r <= 1'b0;
          out_r.taker_id   <= cmd_r.order_id;
          out_r.trade_time <= cmd_r.order_time;
          if (is_cancel) begin
            out_r.item_kind   <= 1'b1;
            out_r.last        <= 1'b1;
            out_r.maker_id    <= '0;
            out_r.trade_price <= '0;
            if (found_r) begin
              valid_r[best_r] <= 1'b0;
              out_r.status <= ST_CANCELLED;
              out_r.trade_quantity <= b_rem;
            end else begin
              out_r.status <= ST_UNKNOWN;
              out_r.trade_quantity <= '0;
            end
            state_r <= S_IDLE;
          end else if (found_r && crosses) begin
            out_r.item_kind <= 1'b0;
            out_r.last <= 1'b0;
            out_r.status <= ST_FILLED;
            out_r.maker_id <= mem_id[best_r];
            out_r.trade_price <= b_price;
            out_r.trade_quantity <= m_qty;
            rem_r <= rem_r - m_qty;
            mem_rem[best_r] <= b_rem - m_qty;
            if (b_rem == m_qty) valid_r[best_r] <= 1'b0;
            state_r <= (rem_r == m_qty) ? S_DONE : S_SCAN;
          end else if (is_market) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_FREE;
          end
        end
        S_FREE: begin
          if (!valid_r[idx_r]) begin
            valid_r[idx_r]   <= 1'b1;
            mem_id[idx_r]    <= cmd_r.order_id;
            mem_side[idx_r]  <= cmd_r.order_side;
            mem_price[idx_r] <= cmd_r.limit_price;
            mem_rem[idx_r]   <= rem_r;
            mem_seq[idx_r]   <= arrival_r;
            arrival_r <= arrival_r + 1'b1;
            found_r <= 1'b1;
            state_r <= S_DONE;
          end else if (last_idx) state_r <= S_DONE;
          else idx_r <= idx_r + 1'b1;
        end
        S_DONE: begin
          out_r.item_kind <= 1'b1;
          out_r.last <= 1'b1;
          out_r.taker_id <= cmd_r.order_id;
          out_r.trade_time <= cmd_r.order_time;
          out_r.maker_id <= '0;
          out_r.trade_price <= '0;
          out_r.trade_quantity <= rem_r;
          if (rem_r == '0) out_r.status <= ST_FILLED;
          else if (is_market) out_r.status <= ST_DROPPED;
          else if (found_r) out_r.status <= ST_RESTED;
          else out_r.status <= ST_FULL;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
